// File: sv/gtoj_pkg.sv
// ----------------------------------------------------------------------------
// gtoj_pkg
// Shared widths, constants, tables and link types for the Gregorian to
// Jalali date converter pipeline.
// ----------------------------------------------------------------------------
package gtoj_pkg;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DAYS_W  = 20;
  localparam int DOY_W   = 9;

  localparam logic [YEAR_W-1:0]  GREG_YEAR_MIN = 12'd1601;
  localparam logic [YEAR_W-1:0]  GREG_EPOCH    = 12'd1600;
  localparam logic [MONTH_W-1:0] MONTH_MIN     = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAX     = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_MIN       = 5'd1;
  localparam logic [YEAR_W-1:0]  JAL_YEAR_BASE = 12'd979;

  localparam logic [6:0]  EPOCH_SHIFT = 7'd79;
  localparam logic [8:0]  YEAR_DAYS   = 9'd365;
  localparam logic [8:0]  LEAP_DAYS   = 9'd366;
  localparam logic [13:0] BIG_CYCLE   = 14'd12053;
  localparam logic [10:0] QUAD_CYCLE  = 11'd1461;
  localparam logic [5:0]  BIG_YEARS   = 6'd33;

  // Reciprocals: x / C == (x * M) >> S over the value ranges used here
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          SHIFT_100   = 19;
  localparam logic [20:0] RECIP_BIG   = 21'd1425361;
  localparam int          SHIFT_BIG   = 34;
  localparam logic [13:0] RECIP_QUAD  = 14'd11484;
  localparam int          SHIFT_QUAD  = 24;

  typedef logic [DAYS_W-1:0] days_t;

  typedef struct packed {
    logic [YEAR_W-1:0] jy;
    logic [DOY_W-1:0]  doy;
  } year_day_t;

  // Days before the first of a Gregorian month (index 0 is January)
  function automatic logic [8:0] greg_start(input logic [MONTH_W-1:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

  // Days before the first of a Jalali month (index 0 is Farvardin)
  function automatic logic [8:0] jal_start(input logic [MONTH_W-1:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd62;
      4'd3:    r = 9'd93;
      4'd4:    r = 9'd124;
      4'd5:    r = 9'd155;
      4'd6:    r = 9'd186;
      4'd7:    r = 9'd216;
      4'd8:    r = 9'd246;
      4'd9:    r = 9'd276;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      default: r = 9'd336;
    endcase
    return r;
  endfunction

endpackage

// File: sv/gtoj_day_count.sv
// ----------------------------------------------------------------------------
// gtoj_day_count
// Two-stage pipeline: clamps the Gregorian date and counts days from the
// Jalali epoch (Gregorian 1600-01-01 plus 79 days).
// ----------------------------------------------------------------------------
module gtoj_day_count (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gtoj_pkg::YEAR_W-1:0]   in_year,
  input  logic [gtoj_pkg::MONTH_W-1:0]  in_month,
  input  logic [gtoj_pkg::DAY_W-1:0]    in_day,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gtoj_pkg::days_t               out_days
);

  logic v1_r, v2_r;
  logic en1, en2;

  logic [11:0] gy_r, gy_nxt;
  logic [19:0] ym_r, ym_nxt;
  logic [23:0] pa_r, pa_nxt;
  logic [23:0] pg_r, pg_nxt;
  logic [9:0]  q4_r, q4_nxt;
  logic [8:0]  md_r, md_nxt;
  logic        late_r, late_nxt;

  gtoj_pkg::days_t days_r, days_nxt;

  logic [11:0] y_c;
  logic [3:0]  m_c;
  logic [4:0]  d_c;
  logic [3:0]  gm;
  logic [4:0]  qa, qg;
  logic        leap;
  logic [20:0] sum;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_comb begin
    y_c = (in_year < gtoj_pkg::GREG_YEAR_MIN) ? gtoj_pkg::GREG_YEAR_MIN : in_year;
    m_c = in_month;
    if (m_c < gtoj_pkg::MONTH_MIN) m_c = gtoj_pkg::MONTH_MIN;
    if (m_c > gtoj_pkg::MONTH_MAX) m_c = gtoj_pkg::MONTH_MAX;
    d_c = (in_day < gtoj_pkg::DAY_MIN) ? gtoj_pkg::DAY_MIN : in_day;
    gm  = m_c - 4'd1;

    gy_nxt   = y_c - gtoj_pkg::GREG_EPOCH;
    ym_nxt   = 20'(gy_nxt) * 20'(gtoj_pkg::YEAR_DAYS);
    pa_nxt   = 24'(gy_nxt + 12'd99) * 24'(gtoj_pkg::RECIP_100);
    pg_nxt   = 24'(gy_nxt) * 24'(gtoj_pkg::RECIP_100);
    q4_nxt   = 10'((gy_nxt + 12'd3) >> 2);
    md_nxt   = gtoj_pkg::greg_start(gm) + 9'(d_c - 5'd1);
    late_nxt = gm > 4'd1;
  end

  always_comb begin
    qa   = 5'(pa_r >> gtoj_pkg::SHIFT_100);
    qg   = 5'(pg_r >> gtoj_pkg::SHIFT_100);
    leap = (gy_r[1:0] == 2'd0) &&
           ((gy_r != 12'(qg * 12'd100)) || (qg[1:0] == 2'd0));
    sum  = 21'(ym_r) + 21'(q4_r) + 21'((6'(qa) + 6'd3) >> 2) + 21'(md_r)
         + 21'(leap && late_r) - 21'(qa) - 21'(gtoj_pkg::EPOCH_SHIFT);
    days_nxt = sum[19:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      gy_r   <= gy_nxt;
      ym_r   <= ym_nxt;
      pa_r   <= pa_nxt;
      pg_r   <= pg_nxt;
      q4_r   <= q4_nxt;
      md_r   <= md_nxt;
      late_r <= late_nxt;
    end
    if (en2 && v1_r) begin
      days_r <= days_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_days  = days_r;

endmodule

// File: sv/gtoj_cycle_split.sv
// ----------------------------------------------------------------------------
// gtoj_cycle_split
// Five-stage pipeline: splits the day count into 33-year groups, 4-year
// groups and years, giving the Jalali year and the day of the year.
// ----------------------------------------------------------------------------
module gtoj_cycle_split (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gtoj_pkg::days_t       in_days,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gtoj_pkg::year_day_t   out_yd
);

  logic v3_r, v4_r, v5_r, v6_r, v7_r;
  logic en3, en4, en5, en6, en7;

  logic [40:0] p3_r, p3_nxt;
  logic [19:0] d3_r;
  logic [13:0] r4_r, r4_nxt;
  logic [11:0] jy4_r, jy4_nxt;
  logic [27:0] p5_r, p5_nxt;
  logic [13:0] r5_r;
  logic [11:0] jy5_r;
  logic [10:0] r6_r, r6_nxt;
  logic [11:0] jy6_r, jy6_nxt;
  logic [8:0]  doy7_r, doy7_nxt;
  logic [11:0] jy7_r, jy7_nxt;

  logic [6:0]  g;
  logic [3:0]  q;
  logic [10:0] d1;
  logic [1:0]  yq;

  assign en7      = !v7_r || out_ready;
  assign en6      = !v6_r || en7;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign in_ready = en3;

  always_comb begin
    p3_nxt  = 41'(in_days) * 41'(gtoj_pkg::RECIP_BIG);

    g       = 7'(p3_r >> gtoj_pkg::SHIFT_BIG);
    r4_nxt  = 14'(d3_r - 20'(g) * 20'(gtoj_pkg::BIG_CYCLE));
    jy4_nxt = gtoj_pkg::JAL_YEAR_BASE + 12'(g) * 12'(gtoj_pkg::BIG_YEARS);

    p5_nxt  = 28'(r4_r) * 28'(gtoj_pkg::RECIP_QUAD);

    q       = 4'(p5_r >> gtoj_pkg::SHIFT_QUAD);
    r6_nxt  = 11'(r5_r - 14'(q) * 14'(gtoj_pkg::QUAD_CYCLE));
    jy6_nxt = jy5_r + 12'({q, 2'b00});

    d1 = r6_r - 11'd1;
    if (d1 >= 11'd1095)      yq = 2'd3;
    else if (d1 >= 11'd730)  yq = 2'd2;
    else                     yq = 2'd1;
    if (r6_r >= 11'(gtoj_pkg::LEAP_DAYS)) begin
      doy7_nxt = 9'(d1 - 11'(yq) * 11'(gtoj_pkg::YEAR_DAYS));
      jy7_nxt  = jy6_r + 12'(yq);
    end else begin
      doy7_nxt = r6_r[8:0];
      jy7_nxt  = jy6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en3) v3_r <= in_valid;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && in_valid) begin
      p3_r <= p3_nxt;
      d3_r <= in_days;
    end
    if (en4 && v3_r) begin
      r4_r  <= r4_nxt;
      jy4_r <= jy4_nxt;
    end
    if (en5 && v4_r) begin
      p5_r  <= p5_nxt;
      r5_r  <= r4_r;
      jy5_r <= jy4_r;
    end
    if (en6 && v5_r) begin
      r6_r  <= r6_nxt;
      jy6_r <= jy6_nxt;
    end
    if (en7 && v6_r) begin
      doy7_r <= doy7_nxt;
      jy7_r  <= jy7_nxt;
    end
  end

  assign out_valid  = v7_r;
  assign out_yd.jy  = jy7_r;
  assign out_yd.doy = doy7_r;

  a_big_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (r4_r < gtoj_pkg::BIG_CYCLE))
    else $error("33-year remainder out of range");

  a_quad_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> (r6_r < gtoj_pkg::QUAD_CYCLE))
    else $error("4-year remainder out of range");

  a_doy: assert property (@(posedge clk) disable iff (!rst_n)
    v7_r |-> (doy7_r < gtoj_pkg::LEAP_DAYS))
    else $error("day of year out of range");

endmodule

// File: sv/gtoj_month_walk.sv
// ----------------------------------------------------------------------------
// gtoj_month_walk
// Output stage: finds the Jalali month from the day of the year against the
// month start table and holds the result beat.
// ----------------------------------------------------------------------------
module gtoj_month_walk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gtoj_pkg::year_day_t           in_yd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gtoj_pkg::YEAR_W-1:0]   out_year,
  output logic [gtoj_pkg::MONTH_W-1:0]  out_month,
  output logic [gtoj_pkg::DAY_W-1:0]    out_day
);

  logic v_r;
  logic en;

  logic [gtoj_pkg::YEAR_W-1:0]  year_r;
  logic [gtoj_pkg::MONTH_W-1:0] month_r, month_nxt;
  logic [gtoj_pkg::DAY_W-1:0]   day_r, day_nxt;
  logic [gtoj_pkg::MONTH_W-1:0] idx;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  always_comb begin
    idx = '0;
    for (int k = 1; k < 12; k++) begin
      if (in_yd.doy >= gtoj_pkg::jal_start(4'(k))) idx = 4'(k);
    end
    month_nxt = idx + 4'd1;
    day_nxt   = 5'(in_yd.doy - gtoj_pkg::jal_start(idx) + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      year_r  <= in_yd.jy;
      month_r <= month_nxt;
      day_r   <= day_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_year  = year_r;
  assign out_month = month_r;
  assign out_day   = day_r;

  a_month: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (month_r >= gtoj_pkg::MONTH_MIN && month_r <= gtoj_pkg::MONTH_MAX))
    else $error("month out of range");

  a_day: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (day_r != 5'd0 && (month_r <= 4'd6 || day_r <= 5'd30)))
    else $error("day exceeds month length");

endmodule

// File: sv/gregorian_to_jalali_date.sv
// Throughput: one date per cycle; the pipeline stalls only where a result is
// not taken, and empty stages keep filling behind a held output.
// Reset: synchronous, active low; clears all stage valid bits, data is kept.
// ----------------------------------------------------------------------------
// gregorian_to_jalali_date
// Converts a Gregorian date to the Jalali (solar hijri) date through an
// eight-stage pipeline: day count, cycle split, month walk.
// ----------------------------------------------------------------------------
module gregorian_to_jalali_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // greg_year[11:0], greg_month[15:12], greg_day[20:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // jalali_year[11:0], jalali_month[15:12], jalali_day[20:16]
);

  logic                dc_valid, dc_ready;
  gtoj_pkg::days_t     dc_days;
  logic                cs_valid, cs_ready;
  gtoj_pkg::year_day_t cs_yd;

  logic [gtoj_pkg::YEAR_W-1:0]  jal_year;
  logic [gtoj_pkg::MONTH_W-1:0] jal_month;
  logic [gtoj_pkg::DAY_W-1:0]   jal_day;

  gtoj_day_count u_day_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_year   (in_tdata[11:0]),
    .in_month  (in_tdata[15:12]),
    .in_day    (in_tdata[20:16]),
    .out_valid (dc_valid),
    .out_ready (dc_ready),
    .out_days  (dc_days)
  );

  gtoj_cycle_split u_cycle_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dc_valid),
    .in_ready  (dc_ready),
    .in_days   (dc_days),
    .out_valid (cs_valid),
    .out_ready (cs_ready),
    .out_yd    (cs_yd)
  );

  gtoj_month_walk u_month_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cs_valid),
    .in_ready  (cs_ready),
    .in_yd     (cs_yd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_year  (jal_year),
    .out_month (jal_month),
    .out_day   (jal_day)
  );

  assign out_tdata = {3'b000, jal_day, jal_month, jal_year};

endmodule
